### hdl/dr_pkg.sv
package dr_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned SpanW     = 34;
  localparam int unsigned MantW     = 23;
  localparam int unsigned ProdW     = MantW + SpanW;
  localparam int unsigned TargetW   = 256;
  localparam int unsigned LimitW    = 9;
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [WordW-1:0]  SpanReset  = 32'd1209600;
  localparam logic [LimitW-1:0] LimitReset = 9'd224;

  typedef enum logic [1:0] {
    CFG_TARGET_SPAN  = 2'd0,
    CFG_RETARGET_OFF = 2'd1,
    CFG_LIMIT_BITS   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [WordW-1:0]  target_span;
    logic              retarget_off;
    logic [LimitW-1:0] limit_bits;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    logic              bypass;
    logic [WordW-1:0]  last_bits;
    logic [ProdW-1:0]  prod;
    logic [ShiftW-1:0] shift_bytes;
    logic              zero;
  } entry_t;

endpackage

### hdl/dr_front.sv
module dr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  dr_pkg::cfg_t      cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       last_bits,
  input  logic [31:0]       last_time,
  input  logic [31:0]       first_time,
  output logic              push,
  output dr_pkg::entry_t    push_entry,
  input  logic              q_full
);

  logic                      a_valid_r, a_valid_nxt;
  logic                      b_valid_r, b_valid_nxt;
  logic                      a_ready, b_ready;
  logic [dr_pkg::SpanW-1:0]  a_span_r;
  logic [dr_pkg::MantW-1:0]  a_mant_r;
  logic [dr_pkg::ShiftW-1:0] a_shift_r;
  logic                      a_zero_r, a_bypass_r;
  logic [31:0]               a_bits_r;
  dr_pkg::entry_t            b_entry_r;

  logic signed [34:0]        diff, lo, hi;
  logic [dr_pkg::SpanW-1:0]  span_c;
  logic [7:0]                size;
  logic [7:0]                sb;
  logic [dr_pkg::MantW-1:0]  mant, mant_c;

  assign b_ready  = !b_valid_r || !q_full;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;
  assign push       = b_valid_r && !q_full;
  assign push_entry = b_entry_r;

  always_comb begin
    diff = $signed({3'b000, last_time}) - $signed({3'b000, first_time});
    lo   = $signed({5'b00000, cfg.target_span[31:2]});
    hi   = $signed({1'b0, cfg.target_span, 2'b00});
    if (diff < lo) begin
      span_c = lo[dr_pkg::SpanW-1:0];
    end else if (diff > hi) begin
      span_c = hi[dr_pkg::SpanW-1:0];
    end else begin
      span_c = diff[dr_pkg::SpanW-1:0];
    end
    size = last_bits[31:24];
    mant = last_bits[22:0];
    sb   = size - 8'd3;
    case (size)
      8'd0:    mant_c = '0;
      8'd1:    mant_c = mant >> 16;
      8'd2:    mant_c = mant >> 8;
      default: mant_c = mant;
    endcase
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_ready) begin
      a_valid_nxt = in_valid;
    end
    b_valid_nxt = b_valid_r;
    if (b_ready) begin
      b_valid_nxt = a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
    if (a_ready && in_valid) begin
      a_span_r   <= span_c;
      a_mant_r   <= mant_c;
      a_bits_r   <= last_bits;
      a_bypass_r <= cfg.retarget_off;
      if (size <= 8'd3) begin
        a_shift_r <= '0;
        a_zero_r  <= 1'b0;
      end else begin
        a_shift_r <= sb[dr_pkg::ShiftW-1:0];
        a_zero_r  <= (sb >= 8'd32);
      end
    end
    if (b_ready && a_valid_r) begin
      b_entry_r.bypass      <= a_bypass_r;
      b_entry_r.last_bits   <= a_bits_r;
      b_entry_r.prod        <= {{dr_pkg::SpanW{1'b0}}, a_mant_r} *
                               {{dr_pkg::MantW{1'b0}}, a_span_r};
      b_entry_r.shift_bytes <= a_shift_r;
      b_entry_r.zero        <= a_zero_r;
    end
  end

endmodule

### hdl/dr_queue.sv
module dr_queue #(
  parameter int unsigned Depth = dr_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dr_pkg::entry_t wr_entry,
  input  logic           pop,
  output dr_pkg::entry_t rd_entry,
  output logic           full,
  output logic           empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dr_pkg::entry_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign full     = (cnt_r == CntW'(Depth));
  assign empty    = (cnt_r == '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

### hdl/dr_back.sv
module dr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  dr_pkg::cfg_t   cfg,
  input  logic           q_empty,
  input  dr_pkg::entry_t q_entry,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    new_bits
);

  typedef enum logic [1:0] {IDLE, DIV, CAP, ENC} state_t;

  localparam int unsigned TW = dr_pkg::TargetW;

  state_t          state_r;
  logic [TW-1:0]   v_r;
  logic [31:0]     rem_r;
  logic [7:0]      k_r;
  logic [8:0]      bl_r;
  logic            out_valid_r;
  logic [31:0]     out_r;

  logic            out_free;
  logic            out_load;
  logic [32:0]     trial;
  logic            qbit;
  logic [TW-1:0]   dividend;
  logic [TW-1:0]   mask;
  logic [5:0]      size;
  logic [TW+23:0]  cat;
  logic [23:0]     mant24;
  logic [31:0]     enc;

  assign out_free  = !out_valid_r || out_ready;
  assign pop       = (state_r == IDLE) && !q_empty && out_free;
  assign out_load  = (pop && (q_entry.bypass || cfg.target_span == '0)) ||
                     ((state_r == ENC) && out_free);
  assign out_valid = out_valid_r;
  assign new_bits  = out_r;

  always_comb begin
    trial    = {rem_r, v_r[TW-1]};
    qbit     = (trial >= {1'b0, cfg.target_span});
    dividend = {{(TW-dr_pkg::ProdW){1'b0}}, q_entry.prod} << {q_entry.shift_bytes, 3'b000};
    for (int i = 0; i < TW; i++) begin
      mask[i] = (9'(i) < cfg.limit_bits) || cfg.limit_bits[8];
    end
    size   = 6'((bl_r + 9'd7) >> 3);
    cat    = {v_r, 24'h000000};
    mant24 = cat[{size, 3'b000} +: 24];
    if (mant24[23]) begin
      enc = {2'b00, size + 6'd1, 8'h00, mant24[23:8]};
    end else begin
      enc = {2'b00, size, mant24};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (pop) begin
            if (q_entry.bypass) begin
              out_r <= q_entry.last_bits;
            end else if (cfg.target_span == '0) begin
              out_r <= '0;
            end else begin
              v_r     <= q_entry.zero ? '0 : dividend;
              rem_r   <= '0;
              k_r     <= '0;
              bl_r    <= '0;
              state_r <= DIV;
            end
          end
        end
        DIV: begin
          // shift quotient bits in as dividend bits leave; note first one
          v_r   <= {v_r[TW-2:0], qbit};
          rem_r <= qbit ? 32'(trial - {1'b0, cfg.target_span}) : trial[31:0];
          if (qbit && bl_r == '0) begin
            bl_r <= 9'(TW) - {1'b0, k_r};
          end
          k_r <= k_r + 8'd1;
          if (k_r == 8'hff) begin
            state_r <= CAP;
          end
        end
        CAP: begin
          if (bl_r > cfg.limit_bits) begin
            v_r  <= mask;
            bl_r <= cfg.limit_bits;
          end
          state_r <= ENC;
        end
        ENC: begin
          if (out_free) begin
            out_r   <= enc;
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

### hdl/difficulty_retarget_top.sv
// Difficulty retarget: one compact target word out for each item in.
// Input channel in_*: an item carries the previous compact word and the
// last and first block times of the period; it is taken when in_tvalid and
// in_tready are both high. Output channel out_*: one new compact word per
// item, in order, held until out_tvalid meets out_tready.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 target
// span, 1 bypass, 2 limit width) at the clock edge; write only while idle.
// A retarget item passes through the front (clamp and decode, then mantissa
// times span), the queue, the bit-serial divider in the back end, and then
// cap and encode. The back end takes a new item only once it is idle again,
// so it does not start one item before it is through with the last. Bypass
// items and a zero target span skip the divider and are output directly.
// The front keeps accepting while the back divides, until its pipe and the
// queue (two entries by default) fill; a stalled receiver holds the back end in place.
// Reset (rst_n low, synchronous) empties the pipe and queue and loads the
// register defaults: span 1209600, bypass off, limit 224.
module difficulty_retarget_top #(
  parameter int unsigned QUEUE_DEPTH = dr_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // last_bits[31:0], last_time[63:32], first_time[95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // new_bits[31:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  dr_pkg::cfg_t   cfg_r;
  logic           push, pop, q_full, q_empty;
  dr_pkg::entry_t push_entry, q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_span  <= dr_pkg::SpanReset;
      cfg_r.retarget_off <= 1'b0;
      cfg_r.limit_bits   <= dr_pkg::LimitReset;
    end else if (cfg_we) begin
      case (dr_pkg::cfg_idx_t'(cfg_addr))
        dr_pkg::CFG_TARGET_SPAN:  cfg_r.target_span  <= cfg_wdata;
        dr_pkg::CFG_RETARGET_OFF: cfg_r.retarget_off <= cfg_wdata[0];
        dr_pkg::CFG_LIMIT_BITS:   cfg_r.limit_bits   <= cfg_wdata[dr_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  dr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .last_bits  (in_tdata[31:0]),
    .last_time  (in_tdata[63:32]),
    .first_time (in_tdata[95:64]),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  dr_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .rd_entry (q_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  dr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_entry   (q_entry),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .new_bits  (out_tdata)
  );

endmodule

### verif/difficulty_retarget_top_tb.sv
module difficulty_retarget_top_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // last_bits[31:0], last_time[63:32], first_time[95:64]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;      // new_bits[31:0]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  difficulty_retarget_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the block's registers
  logic [31:0] span_q = dr_pkg::SpanReset;
  logic        bypass_q = 1'b0;
  logic [8:0]  limit_q = dr_pkg::LimitReset;

  logic [31:0] new_bits_q[$];
  int          errors = 0;
  int          sent = 0;
  int          pace = 0;    // 0: sender 22 / receiver 56, 1: swapped, 2: no idling

  typedef struct {
    logic [31:0] word;
    logic [31:0] t_last;
    logic [31:0] t_first;
    bit          typed;
    logic [31:0] want;
  } row_t;

  row_t rows[] = '{
    '{32'h00000000, 32'd1209600, 32'd0, 1'b1, 32'h00000000},
    '{32'h1d00ffff, 32'd1209600, 32'd0, 1'b1, 32'h1d00ffff},
    '{32'hff7fffff, 32'd1209600, 32'd0, 1'b1, 32'h00000000},
    '{32'h00800000, 32'd1209600, 32'd0, 1'b1, 32'h00000000},
    '{32'h01123456, 32'd1209600, 32'd0, 1'b0, 32'h0},
    '{32'h02123456, 32'd9,       32'd0, 1'b0, 32'h0},
    '{32'h03800001, 32'd1209600, 32'd0, 1'b0, 32'h0},
    '{32'h1d00ffff, 32'd0, 32'hffffffff, 1'b0, 32'h0},
    '{32'h1d00ffff, 32'hffffffff, 32'd0, 1'b0, 32'h0},
    '{32'h207fffff, 32'hffffffff, 32'd0, 1'b0, 32'h0},
    '{32'h22ffffff, 32'd5000000, 32'd100, 1'b0, 32'h0},
    '{32'h1c7fffff, 32'd300000,  32'd0, 1'b0, 32'h0},
    '{32'h04ffffff, 32'd2000000, 32'd7, 1'b0, 32'h0},
    '{32'h1e7fffff, 32'd2419200, 32'd0, 1'b0, 32'h0}
  };

  function automatic logic [31:0] retarget(logic [31:0] word, logic [31:0] t_last,
                                           logic [31:0] t_first);
    logic [255:0] tgt, prod, cap;
    longint       span_clamped, lo, hi;
    int           nbytes, nbits;
    logic [31:0]  mant;
    if (bypass_q) return word;
    nbytes = word[31:24];
    if (nbytes <= 3) tgt = 256'(word[22:0]) >> (8 * (3 - nbytes));
    else if (8 * (nbytes - 3) >= 256) tgt = '0;
    else tgt = 256'(word[22:0]) << (8 * (nbytes - 3));
    span_clamped = longint'(t_last) - longint'(t_first);
    lo = longint'(span_q / 4);
    hi = longint'(span_q) * 4;
    if (span_clamped < lo) span_clamped = lo;
    if (span_clamped > hi) span_clamped = hi;
    prod = tgt * 256'(span_clamped);
    if (span_q == 0) prod = '0;
    else prod = prod / 256'(span_q);
    cap = (limit_q >= 256) ? {256{1'b1}} : (256'(1) << limit_q) - 256'(1);
    if (prod > cap) prod = cap;
    nbits = 0;
    for (int i = 255; i >= 0; i--) begin
      if (prod[i]) begin
        nbits = i + 1;
        break;
      end
    end
    nbytes = (nbits + 7) / 8;
    if (nbytes <= 3) mant = (prod[31:0] << (8 * (3 - nbytes))) & 32'h00ffffff;
    else mant = 32'(prod >> (8 * (nbytes - 3))) & 32'h00ffffff;
    if (mant[23]) begin
      mant = mant >> 8;
      nbytes++;
    end
    return mant | (32'(nbytes) << 24);
  endfunction

  task automatic write_reg(dr_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      dr_pkg::CFG_TARGET_SPAN:  span_q = val;
      dr_pkg::CFG_RETARGET_OFF: bypass_q = val[0];
      dr_pkg::CFG_LIMIT_BITS:   limit_q = val[8:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (new_bits_q.size() != 0) @(posedge clk);
  endtask

  task automatic send(logic [31:0] word, logic [31:0] t_last, logic [31:0] t_first,
                      bit typed, logic [31:0] want);
    int gap;
    pace = (sent < 600) ? 0 : (sent < 1200) ? 1 : 2;
    gap = (pace == 0) ? 22 : (pace == 1) ? 56 : 0;
    while ($urandom_range(0, 99) < gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t_first, t_last, word};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    new_bits_q.push_back(typed ? want : retarget(word, t_last, t_first));
    sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (new_bits_q.size() == 0) begin
          $display("%0t: unexpected new_bits %h", $time, out_tdata);
          errors++;
        end else begin
          if (out_tdata !== new_bits_q[0]) begin
            $display("%0t: new_bits expected %h actual %h", $time, new_bits_q[0], out_tdata);
            errors++;
          end
          void'(new_bits_q.pop_front());
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= ((pace == 0) ? 56 : (pace == 1) ? 22 : 0));
  end

  initial begin
    logic [31:0] settings[9][3];
    logic [31:0] word, t_first, t_last;
    logic [63:0] delta;
    settings = '{
      '{32'd1209600, 32'd0, 32'd224},
      '{32'd4,          32'd0, 32'd256},
      '{32'hffffffff,   32'd0, 32'd511},
      '{32'd600,        32'd0, 32'd1},
      '{32'd0,          32'd0, 32'd224},
      '{32'd1209600,    32'd1, 32'd224},
      '{32'd7,          32'd0, 32'd0},
      '{32'h00001000,   32'd0, 32'd255},
      '{32'd1209600,    32'd0, 32'd224}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].word, rows[i].t_last, rows[i].t_first,
                           rows[i].typed, rows[i].want);

    for (int s = 1; s < 9; s++) begin
      // hold off until the block has emptied
      in_tvalid <= 1'b0;
      drain();
      write_reg(dr_pkg::CFG_TARGET_SPAN, settings[s][0]);
      write_reg(dr_pkg::CFG_RETARGET_OFF, settings[s][1]);
      write_reg(dr_pkg::CFG_LIMIT_BITS, settings[s][2]);
      cfg_we <= 1'b0;
      for (int n = 0; n < 225; n++) begin
        if ($urandom_range(0, 7) == 0) word = $urandom;
        else word = {8'($urandom_range(0, 36)), 24'($urandom)};
        t_first = $urandom;
        if ($urandom_range(0, 7) == 0) t_last = $urandom;
        else begin
          delta  = (64'(span_q) * 64'($urandom_range(0, 500))) / 64'd100;
          t_last = t_first + delta[31:0];
        end
        send(word, t_last, t_first, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
hdl/dr_pkg.sv
hdl/dr_front.sv
hdl/dr_queue.sv
hdl/dr_back.sv
hdl/difficulty_retarget_top.sv
verif/difficulty_retarget_top_tb.sv
